/* src/dcd_pkg.sv */
package dcd_pkg;

   // sample and result widths
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = SAMPLE_W + 3;

   // configuration port
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 9;
   localparam int SIZE_RST = 256;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_DIMS   = 2'd0;
   localparam logic [CSR_IW-1:0] REG_SIZE_X = 2'd1;
   localparam logic [CSR_IW-1:0] REG_SIZE_Y = 2'd2;
   localparam logic [CSR_IW-1:0] REG_SIZE_Z = 2'd3;

   // dimension modes
   localparam logic [1:0] DIMS_X   = 2'd1;
   localparam logic [1:0] DIMS_XY  = 2'd2;
   localparam logic [1:0] DIMS_XYZ = 2'd3;

   // item commands
   localparam logic CMD_VOXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] comp_x;
      logic signed [SAMPLE_W-1:0] comp_y;
      logic signed [SAMPLE_W-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] twice_divergence;
      logic                    last_voxel;
   } rsp_type;

   // neighbor enables and end flag for one result in flight
   typedef struct packed {
      logic xp;
      logic xm;
      logic yp;
      logic ym;
      logic zp;
      logic zm;
      logic last;
   } dcd_stage_type;

endpackage

/* src/divergence_central_difference_3d.sv */
// Streams a vector field volume in raster order (x fastest) and returns twice the
// central-difference divergence of each voxel, neighbors outside the volume read as
// zero. One item is taken every cycle unless the output stalls. The result for a
// voxel leaves on the item that brings the voxel one plane, one row and one voxel
// later; after the last voxel, flush items drain the pending results, one each.
// Each component lives in its own ring memory addressed by raster position with one
// write and two reads per cycle, so a result passes a registered memory read and a
// combinational sum before it sits in the output register. After reset and any size
// register write, req_ready stays low while plane and volume sizes are multiplied out.
module divergence_central_difference_3d #(
   parameter int MAX_X = 256,
   parameter int MAX_Y = 256,
   parameter int MAX_Z = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dcd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dcd_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dcd_pkg::CSR_IW-1:0] csr_index,
   input  logic [dcd_pkg::CSR_DW-1:0] csr_data
);
   import dcd_pkg::*;

   localparam longint PLANE_MAX = longint'(MAX_X) * longint'(MAX_Y);
   localparam longint TOTAL_MAX = PLANE_MAX * longint'(MAX_Z);
   localparam int SXW  = $clog2(MAX_X + 1);
   localparam int SYW  = $clog2(MAX_Y + 1);
   localparam int SZW  = $clog2(MAX_Z + 1);
   localparam int PLW  = $clog2(PLANE_MAX + 1);
   localparam int POSW = $clog2(TOTAL_MAX + 1);
   localparam int RAW  = $clog2(2 * PLANE_MAX + MAX_X + 2);
   localparam logic [SXW-1:0] SX_RST = SXW'((MAX_X < SIZE_RST) ? MAX_X : SIZE_RST);
   localparam logic [SYW-1:0] SY_RST = SYW'((MAX_Y < SIZE_RST) ? MAX_Y : SIZE_RST);
   localparam logic [SZW-1:0] SZ_RST = SZW'((MAX_Z < SIZE_RST) ? MAX_Z : SIZE_RST);
   localparam logic [1:0]     SETTLE = 2'd2;

   function automatic int clamp_size(int v, int hi);
      int r;
      r = (v == 0) ? 1 : ((v > hi) ? hi : v);
      return r;
   endfunction

   logic [1:0]      dims_ff;
   logic [SXW-1:0]  sx_ff;
   logic [SYW-1:0]  sy_ff;
   logic [SZW-1:0]  sz_ff;
   logic [PLW-1:0]  plane_ff;
   logic [POSW-1:0] total_ff;
   logic [POSW-1:0] dly_ff;
   logic [1:0]      settle_ff;

   logic [POSW-1:0] in_pos_ff, in_pos_in;
   logic [POSW-1:0] out_pos_ff, out_pos_in;
   logic [POSW-1:0] lag_ff, lag_in;
   logic [SXW-1:0]  ox_ff, ox_in;
   logic [SYW-1:0]  oy_ff, oy_in;
   logic [SZW-1:0]  oz_ff, oz_in;

   logic          csr_wr;
   logic          size_wr;
   logic          acc;
   logic          is_voxel;
   logic          filling;
   logic          out_pend;
   logic          wr;
   logic          emit;
   logic          done;
   logic          s1_free;
   dcd_stage_type emit_info;

   logic [SAMPLE_W-1:0] xp, xm, yp, ym, zp, zm;
   logic [RAW-1:0]      wr_addr;

   // configuration writes, always taken
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign size_wr   = csr_wr && (csr_index == REG_SIZE_X || csr_index == REG_SIZE_Y
                                 || csr_index == REG_SIZE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff   <= DIMS_XYZ;
         sx_ff     <= SX_RST;
         sy_ff     <= SY_RST;
         sz_ff     <= SZ_RST;
         settle_ff <= SETTLE;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               REG_DIMS:   dims_ff <= csr_data[1:0];
               REG_SIZE_X: sx_ff <= SXW'(clamp_size(int'(csr_data), MAX_X));
               REG_SIZE_Y: sy_ff <= SYW'(clamp_size(int'(csr_data), MAX_Y));
               REG_SIZE_Z: sz_ff <= SZW'(clamp_size(int'(csr_data), MAX_Z));
               default: ;
            endcase
         end
         if (size_wr) begin
            settle_ff <= SETTLE;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // plane, volume and delay sizes, registered from the size registers
   always_ff @(posedge clock) begin
      plane_ff <= PLW'(sx_ff * sy_ff);
      total_ff <= POSW'(plane_ff * sz_ff);
      dly_ff   <= POSW'(plane_ff) + POSW'(sx_ff) + POSW'(1);
   end

   // item decode
   assign req_ready = (settle_ff == 2'd0) && s1_free;
   assign acc       = req_valid && req_ready;
   assign is_voxel  = req_data.command == CMD_VOXEL;
   assign filling   = in_pos_ff < total_ff;
   assign out_pend  = out_pos_ff < total_ff;
   assign wr        = acc && filling && is_voxel;
   assign emit      = acc && ((filling && is_voxel && (lag_ff >= dly_ff))
                              || (!filling && out_pend));
   assign done      = (out_pos_ff + POSW'(1)) == total_ff;

   // neighbor enables for the result at the output position
   always_comb begin
      emit_info.xp   = (dims_ff >= DIMS_X) && (ox_ff != sx_ff - SXW'(1));
      emit_info.xm   = (dims_ff >= DIMS_X) && (ox_ff != '0);
      emit_info.yp   = (dims_ff >= DIMS_XY) && (oy_ff != sy_ff - SYW'(1));
      emit_info.ym   = (dims_ff >= DIMS_XY) && (oy_ff != '0);
      emit_info.zp   = (dims_ff >= DIMS_XYZ) && (oz_ff != sz_ff - SZW'(1));
      emit_info.zm   = (dims_ff >= DIMS_XYZ) && (oz_ff != '0);
      emit_info.last = done;
   end

   // positions and output coordinates
   always_comb begin
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      lag_in     = lag_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      oz_in      = oz_ff;
      if (wr) begin
         in_pos_in = in_pos_ff + POSW'(1);
      end
      if (wr && !emit) begin
         lag_in = lag_ff + POSW'(1);
      end else if (emit && !wr) begin
         lag_in = lag_ff - POSW'(1);
      end
      if (emit) begin
         out_pos_in = out_pos_ff + POSW'(1);
         if (ox_ff == sx_ff - SXW'(1)) begin
            ox_in = '0;
            if (oy_ff == sy_ff - SYW'(1)) begin
               oy_in = '0;
               oz_in = oz_ff + SZW'(1);
            end else begin
               oy_in = oy_ff + SYW'(1);
            end
         end else begin
            ox_in = ox_ff + SXW'(1);
         end
      end
      if ((emit && done) || size_wr) begin
         in_pos_in  = '0;
         out_pos_in = '0;
         lag_in     = '0;
         ox_in      = '0;
         oy_in      = '0;
         oz_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         lag_ff     <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         oz_ff      <= '0;
      end else begin
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         lag_ff     <= lag_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         oz_ff      <= oz_in;
      end
   end

   // ring memories, one per component, addressed by raster position
   assign wr_addr = RAW'(in_pos_ff);

   dcd_ring #(.AW(RAW)) u_ring_x (
      .clock     (clock),
      .wr_en     (wr),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.comp_x),
      .rd_en     (emit),
      .rd_addr_a (RAW'(out_pos_ff + POSW'(1))),
      .rd_addr_b (RAW'(out_pos_ff - POSW'(1))),
      .rd_data_a (xp),
      .rd_data_b (xm)
   );

   dcd_ring #(.AW(RAW)) u_ring_y (
      .clock     (clock),
      .wr_en     (wr),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.comp_y),
      .rd_en     (emit),
      .rd_addr_a (RAW'(out_pos_ff + POSW'(sx_ff))),
      .rd_addr_b (RAW'(out_pos_ff - POSW'(sx_ff))),
      .rd_data_a (yp),
      .rd_data_b (ym)
   );

   dcd_ring #(.AW(RAW)) u_ring_z (
      .clock     (clock),
      .wr_en     (wr),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.comp_z),
      .rd_en     (emit),
      .rd_addr_a (RAW'(out_pos_ff + POSW'(plane_ff))),
      .rd_addr_b (RAW'(out_pos_ff - POSW'(plane_ff))),
      .rd_data_a (zp),
      .rd_data_b (zm)
   );

   // sum and output register
   dcd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .emit_info (emit_info),
      .x_plus    (xp),
      .x_minus   (xm),
      .y_plus    (yp),
      .y_minus   (ym),
      .z_plus    (zp),
      .z_minus   (zm),
      .s1_free   (s1_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // checks
   a_lag_bound: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 2'd0) |-> (lag_ff <= dly_ff))
      else $error("input lead exceeds stencil delay");

   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == 2'd0) |-> (out_pos_ff <= in_pos_ff))
      else $error("output position passed input position");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> s1_free)
      else $error("result issued into a busy read stage");

   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      (emit && done && !size_wr) |=> (out_pos_ff == '0 && in_pos_ff == '0))
      else $error("positions not cleared after final result");

endmodule

/* src/dcd_ring.sv */
module dcd_ring #(
   parameter int AW = 18
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [dcd_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr_a,
   input  logic [AW-1:0]                rd_addr_b,
   output logic [dcd_pkg::SAMPLE_W-1:0] rd_data_a,
   output logic [dcd_pkg::SAMPLE_W-1:0] rd_data_b
);
   import dcd_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_a_ff;
   logic [SAMPLE_W-1:0] rd_b_ff;

   // one write, two registered reads, old data on a same-address hit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/dcd_out.sv */
module dcd_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         emit,
   input  dcd_pkg::dcd_stage_type       emit_info,
   input  logic [dcd_pkg::SAMPLE_W-1:0] x_plus,
   input  logic [dcd_pkg::SAMPLE_W-1:0] x_minus,
   input  logic [dcd_pkg::SAMPLE_W-1:0] y_plus,
   input  logic [dcd_pkg::SAMPLE_W-1:0] y_minus,
   input  logic [dcd_pkg::SAMPLE_W-1:0] z_plus,
   input  logic [dcd_pkg::SAMPLE_W-1:0] z_minus,
   output logic                         s1_free,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output dcd_pkg::rsp_type             rsp_data
);
   import dcd_pkg::*;

   logic                    s1_valid_ff;
   dcd_stage_type           s1_info_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;
   logic                    out_free;
   logic                    s1_adv;
   logic signed [OUT_W-1:0] sum;

   function automatic logic signed [OUT_W-1:0] term(logic en, logic [SAMPLE_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      r = en ? {{(OUT_W-SAMPLE_W){v[SAMPLE_W-1]}}, v} : '0;
      return r;
   endfunction

   // handshake between read stage and output register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;

   // central differences of the enabled components
   assign sum = term(s1_info_ff.xp, x_plus) - term(s1_info_ff.xm, x_minus)
              + term(s1_info_ff.yp, y_plus) - term(s1_info_ff.ym, y_minus)
              + term(s1_info_ff.zp, z_plus) - term(s1_info_ff.zm, z_minus);

   always_comb begin
      rsp_data_in.twice_divergence = sum;
      rsp_data_in.last_voxel       = s1_info_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= emit;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      if (emit && s1_free) begin
         s1_info_ff <= emit_info;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/divergence_central_difference_3d_test.sv */
`timescale 1ns / 100ps

module divergence_central_difference_3d_test;
   import dcd_pkg::*;

   localparam int MAXD      = 256;
   localparam int WIN_LEN   = 2 * MAXD * MAXD + MAXD + 4;
   localparam int SETTLE    = 20;
   localparam int MAX_CYC   = 1000000;
   localparam int RAND_ITEMS = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   divergence_central_difference_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // queues between stimulus, predictor and checker
   req_type voxel_queue[$];
   rsp_type divergence_queue[$];
   int errors = 0;
   int cycles = 0;
   logic req_taken = 1'b0;

   // predictor state: sample window, sizes, mode and stream positions
   logic signed [SAMPLE_W-1:0] win_x [WIN_LEN];
   logic signed [SAMPLE_W-1:0] win_y [WIN_LEN];
   logic signed [SAMPLE_W-1:0] win_z [WIN_LEN];
   logic [1:0] dims_mode = DIMS_XYZ;
   logic [CSR_DW-1:0] ext_x = SIZE_RST;
   logic [CSR_DW-1:0] ext_y = SIZE_RST;
   logic [CSR_DW-1:0] ext_z = SIZE_RST;
   longint in_pos = 0;
   longint out_pos = 0;

   function automatic longint clamp_ext(logic [CSR_DW-1:0] v);
      if (v == 0) return 1;
      if (v > MAXD) return MAXD;
      return v;
   endfunction

   // sum the central differences for the next voxel due out
   function automatic rsp_type divergence_of_next();
      longint sx, sy, sz, plane, total, p, x, y, z, sum;
      rsp_type r;
      sx = clamp_ext(ext_x);
      sy = clamp_ext(ext_y);
      sz = clamp_ext(ext_z);
      plane = sx * sy;
      total = plane * sz;
      p = out_pos;
      x = p % sx;
      y = (p / sx) % sy;
      z = p / plane;
      sum = 0;
      if (dims_mode >= DIMS_X) begin
         if (x + 1 < sx) sum += win_x[(p + 1) % WIN_LEN];
         if (x > 0) sum -= win_x[(p - 1) % WIN_LEN];
      end
      if (dims_mode >= DIMS_XY) begin
         if (y + 1 < sy) sum += win_y[(p + sx) % WIN_LEN];
         if (y > 0) sum -= win_y[(p - sx) % WIN_LEN];
      end
      if (dims_mode >= DIMS_XYZ) begin
         if (z + 1 < sz) sum += win_z[(p + plane) % WIN_LEN];
         if (z > 0) sum -= win_z[(p - plane) % WIN_LEN];
      end
      r.twice_divergence = sum[OUT_W-1:0];
      r.last_voxel = (p + 1 == total);
      out_pos++;
      if (out_pos >= total) begin
         out_pos = 0;
         in_pos = 0;
      end
      return r;
   endfunction

   // advance the stream by one accepted item
   function automatic void predict_divergence(req_type it);
      longint sx, sy, sz, total, lag, slot;
      sx = clamp_ext(ext_x);
      sy = clamp_ext(ext_y);
      sz = clamp_ext(ext_z);
      total = sx * sy * sz;
      lag = sx * sy + sx + 1;
      if (in_pos < total) begin
         if (it.command == CMD_FLUSH) return;
         slot = in_pos % WIN_LEN;
         win_x[slot] = it.comp_x;
         win_y[slot] = it.comp_y;
         win_z[slot] = it.comp_z;
         in_pos++;
         if (in_pos >= out_pos + lag + 1) divergence_queue.push_back(divergence_of_next());
      end else if (out_pos < total) begin
         divergence_queue.push_back(divergence_of_next());
      end
   endfunction

   // monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("DONE: errors detected");
         $finish;
      end
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DIMS: dims_mode = csr_data[1:0];
               REG_SIZE_X: begin ext_x = csr_data; in_pos = 0; out_pos = 0; end
               REG_SIZE_Y: begin ext_y = csr_data; in_pos = 0; out_pos = 0; end
               REG_SIZE_Z: begin ext_z = csr_data; in_pos = 0; out_pos = 0; end
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_divergence(req_data);
         if (rsp_valid && rsp_ready) begin
            if (divergence_queue.size() == 0) begin
               $error("result with nothing expected: twice_divergence %0d",
                      rsp_data.twice_divergence);
               errors++;
            end else begin
               want = divergence_queue.pop_front();
               if (rsp_data.twice_divergence !== want.twice_divergence) begin
                  $error("twice_divergence expected %0d actual %0d",
                         want.twice_divergence, rsp_data.twice_divergence);
                  errors++;
               end
               if (rsp_data.last_voxel !== want.last_voxel) begin
                  $error("last_voxel expected %0d actual %0d",
                         want.last_voxel, rsp_data.last_voxel);
                  errors++;
               end
            end
         end
      end
   end

   // driver: bursts of items separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (voxel_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= voxel_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between modes every so often
   int stall_mode = 0;
   int mode_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(3, 0);
         mode_left <= $urandom_range(200, 30);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1, 0));
         2: rsp_ready <= (cycles % 4 == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(7, 0) == 0) stall_left <= $urandom_range(12, 1);
            end
         end
      endcase
   end

   // stimulus helpers
   task automatic wait_quiet();
      wait (voxel_queue.size() == 0 && !req_valid && divergence_queue.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic setup_volume(logic [1:0] d, int x, int y, int z);
      wait_quiet();
      write_reg(REG_DIMS, CSR_DW'(d));
      write_reg(REG_SIZE_X, CSR_DW'(x));
      write_reg(REG_SIZE_Y, CSR_DW'(y));
      write_reg(REG_SIZE_Z, CSR_DW'(z));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9, 0))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic req_type make_voxel();
      req_type it;
      it.command = CMD_VOXEL;
      it.comp_x = pick_sample();
      it.comp_y = pick_sample();
      it.comp_z = pick_sample();
      return it;
   endfunction

   function automatic req_type make_flush();
      req_type it;
      it = make_voxel();
      it.command = CMD_FLUSH;
      return it;
   endfunction

   // queue a volume; full ones get their drain, with stray voxels and extra flushes
   task automatic queue_volume(int x, int y, int z, bit full, output int pushed);
      longint sx, sy, sz, total, lag, n;
      sx = clamp_ext(CSR_DW'(x));
      sy = clamp_ext(CSR_DW'(y));
      sz = clamp_ext(CSR_DW'(z));
      total = sx * sy * sz;
      lag = sx * sy + sx + 1;
      n = full ? total : $urandom_range(total, 1);
      pushed = 0;
      for (longint i = 0; i < n; i++) begin
         if ($urandom_range(9, 0) == 0) voxel_queue.push_back(make_flush());
         voxel_queue.push_back(make_voxel());
         pushed++;
      end
      if (full) begin
         for (longint i = 0; i < lag; i++) begin
            voxel_queue.push_back(($urandom_range(6, 0) == 0) ? make_voxel() : make_flush());
            pushed++;
         end
         repeat ($urandom_range(3, 1)) voxel_queue.push_back(make_flush());
      end
   endtask

   initial begin
      req_type it;
      int pushed;
      int random_count;
      logic signed [SAMPLE_W-1:0] edge_vals [4];
      edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tiny cube with extreme samples, flush before any voxel
      setup_volume(DIMS_XYZ, 2, 2, 2);
      voxel_queue.push_back(make_flush());
      for (int i = 0; i < 8; i++) begin
         it.command = CMD_VOXEL;
         it.comp_x = edge_vals[i % 4];
         it.comp_y = edge_vals[(i + 1) % 4];
         it.comp_z = edge_vals[(i + 3) % 4];
         voxel_queue.push_back(it);
      end
      for (int i = 0; i < 7; i++) voxel_queue.push_back(make_flush());
      voxel_queue.push_back(make_flush());

      // modes none, x and xy, zero and oversized extents, x axis at full length
      setup_volume(2'd0, 3, 2, 2);
      queue_volume(3, 2, 2, 1, pushed);
      setup_volume(DIMS_X, 0, 3, 2);
      queue_volume(0, 3, 2, 1, pushed);
      setup_volume(DIMS_XY, 511, 1, 1);
      queue_volume(511, 1, 1, 1, pushed);

      // random volumes, some cut short and restarted by the next size write
      random_count = 0;
      while (random_count < RAND_ITEMS) begin
         int x, y, z;
         x = $urandom_range(6, 1);
         y = $urandom_range(5, 1);
         z = $urandom_range(4, 1);
         if ($urandom_range(9, 0) == 0) x = $urandom_range(16, 7);
         setup_volume(2'($urandom_range(3, 0)), x, y, z);
         queue_volume(x, y, z, $urandom_range(4, 0) != 0, pushed);
         random_count += pushed;
      end

      wait_quiet();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
